### sv/seenby_address_list_parser_top_assert.svh
// Assertion macros shared by the checker of the address list parser.
`ifndef SEENBY_ADDRESS_LIST_PARSER_TOP_ASSERT_SVH
`define SEENBY_ADDRESS_LIST_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SALP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("address list parser check failed");

// Next-cycle implication, disabled while reset is held.
`define SALP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("address list parser check failed");

`endif

### sv/salp_pkg.sv
`default_nettype none
package salp_pkg;

    // Width of a saturated magnitude, and of a signed part value.
    localparam int NUM_W = 16;
    localparam int VAL_W = NUM_W + 1;
    // Width of the result ports.
    localparam int OUT_W = 17;
    // Largest magnitude a part can reach.
    localparam logic [NUM_W-1:0] MAG_MAX = {NUM_W{1'b1}};

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Classified input word handed from the front to the back.
    typedef struct packed {
        logic       is_space;
        logic       is_slash;
        logic       is_ws;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] digit;
        logic       eot;
    } t_cls;

    // Result word held in the output queue.
    typedef struct packed {
        logic [OUT_W-1:0] net;
        logic [OUT_W-1:0] node;
        logic             has_address;
        logic             text_done;
    } t_res;

    function automatic logic [VAL_W-1:0] apply_sign(input logic [VAL_W-1:0] mag,
                                                   input logic neg);
        logic [VAL_W-1:0] res;
        res = neg ? (~mag + {{(VAL_W-1){1'b0}}, 1'b1}) : mag;
        return res;
    endfunction

endpackage
`default_nettype wire

### sv/seenby_address_list_parser_top.sv
// Path: a pushed word is registered in the front queue, and its result is
// registered in the output queue, whose head drives the result ports.
// Throughput: one word per cycle, sustained, in both directions, while the receiver pops and neither queue fills.
// Reset: i_rst_n is synchronous and active low; it empties both queues and
// returns the parse state, including the remembered network, to zero.
`default_nettype none
module seenby_address_list_parser_top
    import salp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_end_of_text,
    output logic                   empty,
    input  wire logic              pop,
    output logic signed [OUT_W-1:0] o_net_number,
    output logic signed [OUT_W-1:0] o_node_number,
    output logic                   o_has_address,
    output logic                   o_text_done
);

    // The front classifies each character into a short word of flags (space,
    // slash, white space, sign, digit) and parks it in a two-entry queue. The
    // back drains that queue one word per cycle while its output queue has room, runs the token and number
    // parser, and writes any result word into its own two-entry output queue.
    // Either side can stall without stopping the other for up to two words.

    t_cls cls;
    logic cls_valid;
    logic cls_ready;
    t_res res;

    salp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_cls_valid   (cls_valid),
        .o_cls         (cls),
        .i_cls_ready   (cls_ready)
    );

    salp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (cls_valid),
        .i_cls       (cls),
        .o_cls_ready (cls_ready),
        .o_empty     (empty),
        .o_res       (res),
        .i_pop       (pop)
    );

    // Results come straight from the output queue head.
    assign o_net_number  = res.net;
    assign o_node_number = res.node;
    assign o_has_address = res.has_address;
    assign o_text_done   = res.text_done;

endmodule
`default_nettype wire

### sv/salp_front.sv
`default_nettype none
module salp_front
    import salp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_text,
    output logic            o_cls_valid,
    output t_cls            o_cls,
    input  wire logic       i_cls_ready
);

    // Two-entry queue of classified words.
    t_cls       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       push_ok;
    logic       pop_ok;
    t_cls       cls;

    always_comb begin
        cls          = '0;
        cls.is_space = (i_text_byte == CH_SPACE);
        cls.is_slash = (i_text_byte == CH_SLASH);
        cls.is_ws    = (i_text_byte >= CH_TAB) && (i_text_byte <= CH_CR);
        cls.is_sign  = (i_text_byte == CH_PLUS) || (i_text_byte == CH_MINUS);
        cls.is_minus = (i_text_byte == CH_MINUS);
        cls.is_digit = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
        cls.digit    = i_text_byte[3:0];
        cls.eot      = i_end_of_text;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cls_valid = (r_cnt != 2'd0);
    assign o_cls       = r_q[r_rd];
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = o_cls_valid && i_cls_ready;

    always_comb begin
        n_wr  = push_ok ? !r_wr : r_wr;
        n_rd  = pop_ok ? !r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule
`default_nettype wire

### sv/salp_back.sv
`default_nettype none
module salp_back
    import salp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cls_valid,
    input  wire t_cls i_cls,
    output logic      o_cls_ready,
    output logic      o_empty,
    output t_res      o_res,
    input  wire logic i_pop
);

    // Parse state.
    logic             r_token_open;
    logic             r_slash_seen;
    t_phase           r_phase;
    logic             r_neg;
    logic [VAL_W-1:0] r_first;
    logic [VAL_W-1:0] r_second;
    logic [VAL_W-1:0] r_rem_net;

    logic             n_token_open;
    logic             n_slash_seen;
    t_phase           n_phase;
    logic             n_neg;
    logic [VAL_W-1:0] n_first;
    logic [VAL_W-1:0] n_second;
    logic [VAL_W-1:0] n_rem_net;

    // Output queue.
    t_res       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic             take;
    logic             close_now;
    logic             emit;
    logic [NUM_W-1:0] mag;
    logic [NUM_W+3:0] mag_next;
    logic [NUM_W-1:0] mag_sat;
    logic [VAL_W-1:0] close_net;
    logic [VAL_W-1:0] close_node;
    t_res             res;
    logic             pop_ok;

    assign o_cls_ready = (r_cnt != 2'd2);
    assign take        = i_cls_valid && o_cls_ready;
    assign o_empty     = (r_cnt == 2'd0);
    assign o_res       = r_q[r_rd];
    assign pop_ok      = i_pop && !o_empty;

    // Decimal accumulate with saturation on the part being read.
    always_comb begin
        mag      = r_slash_seen ? r_second[NUM_W-1:0] : r_first[NUM_W-1:0];
        mag_next = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0}
                 + {{NUM_W{1'b0}}, i_cls.digit};
        mag_sat  = (mag_next > {4'd0, MAG_MAX}) ? MAG_MAX : mag_next[NUM_W-1:0];
    end

    always_comb begin
        n_token_open = r_token_open;
        n_slash_seen = r_slash_seen;
        n_phase      = r_phase;
        n_neg        = r_neg;
        n_first      = r_first;
        n_second     = r_second;
        n_rem_net    = r_rem_net;
        close_net    = '0;
        close_node   = '0;
        close_now    = 1'b0;
        emit         = 1'b0;
        res          = '0;

        if (take) begin
            if (!i_cls.is_space) begin
                n_token_open = 1'b1;
                if (i_cls.is_slash && !r_slash_seen) begin
                    n_first      = apply_sign(r_first, r_neg);
                    n_slash_seen = 1'b1;
                    n_phase      = PH_LEAD;
                    n_neg        = 1'b0;
                    n_second     = '0;
                end else if (r_phase != PH_DONE) begin
                    if (i_cls.is_digit) begin
                        if (r_slash_seen) begin
                            n_second = {1'b0, mag_sat};
                        end else begin
                            n_first = {1'b0, mag_sat};
                        end
                        n_phase = PH_DIGITS;
                    end else if (i_cls.is_ws && r_phase == PH_LEAD) begin
                        n_phase = PH_LEAD;
                    end else if (i_cls.is_sign && r_phase == PH_LEAD) begin
                        n_neg   = i_cls.is_minus;
                        n_phase = PH_SIGN;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end

            close_now = i_cls.is_space ? r_token_open : i_cls.eot;

            if (n_slash_seen) begin
                close_net  = n_first;
                close_node = apply_sign(n_second, n_neg);
            end else begin
                close_net  = n_rem_net;
                close_node = apply_sign(n_first, n_neg);
            end

            if (close_now && n_slash_seen) begin
                n_rem_net = n_first;
            end

            if (close_now || i_cls.eot) begin
                n_token_open = 1'b0;
                n_slash_seen = 1'b0;
                n_phase      = PH_LEAD;
                n_neg        = 1'b0;
                n_first      = '0;
                n_second     = '0;
            end
            if (i_cls.eot) begin
                n_rem_net = '0;
            end

            emit            = close_now || i_cls.eot;
            res.net         = close_now ? OUT_W'(close_net) : '0;
            res.node        = close_now ? OUT_W'(close_node) : '0;
            res.has_address = close_now;
            res.text_done   = i_cls.eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_open <= 1'b0;
            r_slash_seen <= 1'b0;
            r_phase      <= PH_LEAD;
            r_neg        <= 1'b0;
            r_first      <= '0;
            r_second     <= '0;
            r_rem_net    <= '0;
            r_wr         <= 1'b0;
            r_rd         <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            r_token_open <= n_token_open;
            r_slash_seen <= n_slash_seen;
            r_phase      <= n_phase;
            r_neg        <= n_neg;
            r_first      <= n_first;
            r_second     <= n_second;
            r_rem_net    <= n_rem_net;
            if (emit) begin
                r_wr <= !r_wr;
            end
            if (pop_ok) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, emit} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q[r_wr] <= res;
        end
    end

endmodule
`default_nettype wire

### sv/seenby_address_list_parser_chk.sv
`default_nettype none
`include "seenby_address_list_parser_top_assert.svh"
module seenby_address_list_parser_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic [7:0]  i_text_byte,
    input wire logic        i_end_of_text,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [16:0] o_net_number,
    input wire logic [16:0] o_node_number,
    input wire logic        o_has_address,
    input wire logic        o_text_done
);

    // Both queues come out of reset empty.
    `SALP_ASSERT_NOW(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), empty && !full)
    // A word without an address carries zero numbers.
    `SALP_ASSERT_NOW(a_no_addr_zero, i_clk, i_rst_n, !empty && !o_has_address, o_net_number == 17'd0 && o_node_number == 17'd0)
    // Magnitudes saturate, so the most negative code never shows.
    `SALP_ASSERT_NOW(a_node_range, i_clk, i_rst_n, !empty, !(o_node_number[16] && o_node_number[15:0] == 16'd0))
    // A result that is not taken stays put.
    `SALP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_net_number) && $stable(o_node_number) && $stable(o_text_done))

endmodule

bind seenby_address_list_parser_top seenby_address_list_parser_chk u_chk (.*);
`default_nettype wire

### tb/seenby_address_list_parser_top_tb.sv
`default_nettype none
module seenby_address_list_parser_top_tb;
    import salp_pkg::*;

    // Run limits. The cycle limit covers every word waiting out the longest
    // sender gap and the longest receiver stall, plus the long receiver hold.
    localparam int unsigned WORD_TARGET  = 2000;
    localparam int unsigned HOLD_CYCLES  = 1500;
    localparam int unsigned HOLD_AT_WORD = 700;
    localparam int unsigned DRAIN_AT     = 1000;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    // Predicts the results of the parser and keeps the results still owed.
    class address_scoreboard;
        t_res             owed_q[$];
        int unsigned      errors;
        logic             tok_open;
        logic             after_slash;
        logic             part_neg;
        t_phase           phase;
        logic [VAL_W-1:0] first_val;
        logic [VAL_W-1:0] second_val;
        logic [VAL_W-1:0] net_memory;

        function new();
            errors = 0;
            clear_token();
            net_memory = '0;
        endfunction

        function void clear_token();
            tok_open    = 1'b0;
            after_slash = 1'b0;
            phase       = PH_LEAD;
            part_neg    = 1'b0;
            first_val   = '0;
            second_val  = '0;
        endfunction

        function logic [VAL_W-1:0] signed_part(logic [VAL_W-1:0] mag, logic neg);
            return neg ? ({VAL_W{1'b0}} - mag) : mag;
        endfunction

        // One character of a part, read the way a text-to-integer routine does.
        function logic [VAL_W-1:0] feed_part(logic [VAL_W-1:0] mag, logic [7:0] ch);
            logic        is_ws;
            logic        is_sign;
            logic        is_digit;
            logic [31:0] grown;
            is_ws    = (ch >= CH_TAB) && (ch <= CH_CR);
            is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
            is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
            if (phase == PH_DONE) begin
                return mag;
            end
            if (is_digit) begin
                grown = 32'(mag) * 32'd10 + 32'(ch - CH_ZERO);
                mag   = (grown > 32'(MAG_MAX)) ? VAL_W'(MAG_MAX) : VAL_W'(grown);
                phase = PH_DIGITS;
            end else if (is_ws && phase == PH_LEAD) begin
                // Leading white space is skipped.
            end else if (is_sign && phase == PH_LEAD) begin
                part_neg = (ch == CH_MINUS);
                phase    = PH_SIGN;
            end else begin
                phase = PH_DONE;
            end
            return mag;
        endfunction

        function t_res close_token();
            t_res res;
            res = '0;
            if (after_slash) begin
                res.net    = first_val;
                res.node   = signed_part(second_val, part_neg);
                net_memory = first_val;
            end else begin
                res.net  = net_memory;
                res.node = signed_part(first_val, part_neg);
            end
            res.has_address = 1'b1;
            clear_token();
            return res;
        endfunction

        function void note_word(logic [7:0] ch, logic eot);
            t_res res;
            logic have;
            res  = '0;
            have = 1'b0;
            if (ch == CH_SPACE) begin
                if (tok_open) begin
                    res  = close_token();
                    have = 1'b1;
                end
            end else begin
                tok_open = 1'b1;
                if (ch == CH_SLASH && !after_slash) begin
                    first_val   = signed_part(first_val, part_neg);
                    after_slash = 1'b1;
                    phase       = PH_LEAD;
                    part_neg    = 1'b0;
                    second_val  = '0;
                end else if (after_slash) begin
                    second_val = feed_part(second_val, ch);
                end else begin
                    first_val = feed_part(first_val, ch);
                end
            end
            if (eot) begin
                if (tok_open) begin
                    res  = close_token();
                    have = 1'b1;
                end
                clear_token();
                net_memory = '0;
            end
            if (have || eot) begin
                res.text_done = eot;
                owed_q.push_back(res);
            end
        endfunction

        function void mismatch(string field, int want, int got);
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(logic [OUT_W-1:0] net, logic [OUT_W-1:0] node,
                                   logic has, logic done);
            t_res want;
            if (owed_q.size() == 0) begin
                $display("%0t: result with nothing expected, net %0d node %0d", $time,
                         $signed(net), $signed(node));
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (net !== want.net)
                mismatch("net_number", $signed(want.net), $signed(net));
            if (node !== want.node)
                mismatch("node_number", $signed(want.node), $signed(node));
            if (has !== want.has_address)
                mismatch("has_address", want.has_address, has);
            if (done !== want.text_done)
                mismatch("text_done", want.text_done, done);
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic [7:0]              i_text_byte;
    logic                    i_end_of_text;
    logic                    empty;
    logic                    pop;
    logic signed [OUT_W-1:0] o_net_number;
    logic signed [OUT_W-1:0] o_node_number;
    logic                    o_has_address;
    logic                    o_text_done;

    address_scoreboard sb;
    int unsigned       words_sent;
    int unsigned       cycle_count;
    int unsigned       hold_left;
    logic              hold_done;
    logic              receiver_holding;
    logic              sender_calm;
    // Characters of the next text, each with its end-of-text flag on top.
    logic [8:0]        text_q[$];

    seenby_address_list_parser_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_net_number  (o_net_number),
        .o_node_number (o_node_number),
        .o_has_address (o_has_address),
        .o_text_done   (o_text_done)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("seenby_address_list_parser_top_tb: FAIL");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then a long one. A calm
    // stretch has no idling at all.
    function automatic int unsigned gap_len(logic calm);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offers one word after a random gap and waits until the parser takes it.
    // The valid level is only ever written once per falling edge, so a word
    // that follows another with no gap keeps push high without a glitch.
    task automatic offer_word(logic [7:0] ch, logic eot);
        int unsigned idle;
        idle = receiver_holding ? 0 : gap_len(sender_calm);
        if (idle > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_text_byte   <= ch;
        i_end_of_text <= eot;
        do
            @(posedge i_clk);
        while (full);
        sb.note_word(ch, eot);
        words_sent++;
    endtask

    task automatic offer_string(string s, logic eot_last);
        for (int k = 0; k < s.len(); k++)
            offer_word(s[k], eot_last && (k == s.len() - 1));
    endtask

    // The sender stops and waits until every owed result has been popped.
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // One part of an address: optional white space and sign, then digits.
    // A few runs are long enough to saturate, a few are empty, and now and
    // then white space falls after the digits and ends the part early.
    task automatic add_part();
        int unsigned ndig;
        int unsigned pick;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back({1'b0, 8'($urandom_range(9, 13))});
        if ($urandom_range(0, 3) == 0)
            text_q.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS});
        pick = $urandom_range(0, 9);
        ndig = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        repeat (ndig) text_q.push_back({1'b0, 8'(CH_ZERO + $urandom_range(0, 9))});
        if ($urandom_range(0, 19) == 0) begin
            text_q.push_back({1'b0, 8'($urandom_range(9, 13))});
            text_q.push_back({1'b0, 8'(CH_ZERO + $urandom_range(0, 9))});
        end
    endtask

    task automatic add_token();
        add_part();
        if ($urandom_range(0, 9) < 7) begin
            text_q.push_back({1'b0, CH_SLASH});
            add_part();
            // A second slash is just junk that ends the node part.
            if ($urandom_range(0, 19) == 0) begin
                text_q.push_back({1'b0, CH_SLASH});
                add_part();
            end
        end
    endtask

    // Builds one text. Most are well-formed lists; some carry a stray byte,
    // and some are pure noise with spaces mixed in.
    task automatic build_text();
        int unsigned ntok;
        int unsigned ending;
        int unsigned spot;
        text_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20))
                text_q.push_back({1'b0, ($urandom_range(0, 3) == 0) ? CH_SPACE
                                                                     : 8'($urandom_range(0, 255))});
        end else begin
            ntok = $urandom_range(0, 6);
            repeat ($urandom_range(0, 2)) text_q.push_back({1'b0, CH_SPACE});
            for (int t = 0; t < ntok; t++) begin
                if (t > 0)
                    repeat ($urandom_range(1, 3)) text_q.push_back({1'b0, CH_SPACE});
                add_token();
            end
            ending = $urandom_range(0, 3);
            if (ending == 2)
                text_q.push_back({1'b0, CH_SPACE});
            if (ending >= 2 || text_q.size() == 0)
                text_q.push_back({1'b0, CH_SPACE});
            if ($urandom_range(0, 9) == 0) begin
                spot = $urandom_range(0, text_q.size() - 1);
                text_q[spot] = {1'b0, 8'($urandom_range(0, 255))};
            end
        end
        text_q[text_q.size() - 1][8] = 1'b1;
    endtask

    // Receiver: pops at random, with one long hold-off once the sender is
    // well under way, so that both queues fill and push is refused.
    initial begin : receiver
        int unsigned stall_left;
        logic        recv_calm;
        pop              = 1'b0;
        hold_left        = 0;
        hold_done        = 1'b0;
        receiver_holding = 1'b0;
        stall_left       = 0;
        recv_calm        = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && words_sent >= HOLD_AT_WORD) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    recv_calm = !recv_calm;
                stall_left = gap_len(recv_calm);
            end
            receiver_holding = (hold_left > 0);
            @(posedge i_clk);
            if (pop && !empty)
                sb.check_result(o_net_number, o_node_number, o_has_address, o_text_done);
        end
    end

    initial begin
        sb            = new();
        words_sent    = 0;
        cycle_count   = 0;
        sender_calm   = 1'b0;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_text_byte   = '0;
        i_end_of_text = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts. A saturated negative network closed by a space,
        // then a bare node that takes the remembered network.
        offer_string("-70000/5 ", 1'b0);
        offer_string("8 ", 1'b0);
        // Empty network and a second slash, with the end mark on a digit.
        offer_string("/4/9", 1'b1);
        // End of text with no token open.
        offer_string(" ", 1'b1);
        // A lone sign followed by the zero byte and the all-ones byte, then
        // a space that both closes the token and ends the text.
        offer_string("+", 1'b0);
        offer_word(8'h00, 1'b0);
        offer_word(8'hff, 1'b0);
        offer_string(" ", 1'b1);
        // Leading tab and an empty node; the next text must start from a
        // network of zero again.
        offer_string("\t3/", 1'b1);
        offer_string("7 ", 1'b1);
        wait_drained();

        // Random texts; each text that starts in a window in the middle first waits until all results are in.
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= DRAIN_AT && words_sent < DRAIN_AT + 60)
                wait_drained();
            build_text();
            sender_calm = ($urandom_range(0, 4) == 0);
            foreach (text_q[k])
                offer_word(text_q[k][7:0], text_q[k][8]);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("seenby_address_list_parser_top_tb: PASS");
        end else begin
            $display("seenby_address_list_parser_top_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
